// File: sv/deadline_ordered_timer_set_macros.svh
// assertion macros for the timer set
`ifndef DEADLINE_ORDERED_TIMER_SET_MACROS_SVH
`define DEADLINE_ORDERED_TIMER_SET_MACROS_SVH

// a property that holds at every edge out of reset
`define DOTS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// a property that holds at every edge, reset included
`define DOTS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/dots_pkg.sv
//------------------------------------------------------------------------------
// dots_pkg
// shared types, codes and constants of the deadline ordered timer set
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package dots_pkg;

    localparam int unsigned NUM_TIMERS_DEF = 8;
    localparam int unsigned MASK_W         = 8;
    localparam int unsigned ID_W           = 3;
    localparam int unsigned TICK_W         = 32;
    localparam int unsigned ADV_W          = 16;
    localparam int unsigned PER_W          = 16;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_START   = 3'd1;
    localparam logic [2:0] OP_RESTART = 3'd2;
    localparam logic [2:0] OP_STOP    = 3'd3;
    localparam logic [2:0] OP_QUERY   = 3'd4;

    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [2:0]        operation;
        logic [ID_W-1:0]   timer_id;
        logic [TICK_W-1:0] interval_value;
        logic [ADV_W-1:0]  tick_advance;
    } t_in_item;

    typedef struct packed {
        logic              result_kind;
        logic [ID_W-1:0]   slot_id;
        logic [PER_W-1:0]  periods_elapsed;
        logic [TICK_W-1:0] remaining_ticks;
        logic              slot_active;
        logic [TICK_W-1:0] slot_interval;
        logic [TICK_W-1:0] next_wait;
        logic              last_result;
    } t_out_item;

endpackage

// File: sv/deadline_ordered_timer_set.sv
//------------------------------------------------------------------------------
// deadline_ordered_timer_set
// timer slots kept in deadline order, with a shared tick count
//------------------------------------------------------------------------------
// usage:
//   i_in_valid/o_in_ready take one request transaction (tick, start, restart,
//   stop, query); o_out_valid/i_out_ready return zero or more expiry events
//   and then one status transaction flagged by last_result.
//   i_cfg_valid/o_cfg_ready writes the periodic mask; write it only when idle.
// timing:
//   one request at a time. A start or restart walks the slots once to find its
//   place; a tick adds, per event, one slot scan plus a bit-serial divider for
//   a periodic catch-up and a reinsertion scan. All remaining-time compares go
//   through one shared subtract/compare unit visiting one slot per cycle
//   while no pending result holds the sequencer.
// reset:
//   synchronous active-low reset stops every slot and clears tick count,
//   starts, intervals and mask.
// stall:
//   a pending result holds in the output register while o_out_valid is high;
//   the sequencer waits until it is taken.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module deadline_ordered_timer_set #(
    parameter int unsigned NUM_TIMERS = dots_pkg::NUM_TIMERS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  dots_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output dots_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [dots_pkg::MASK_W-1:0] i_cfg_data
);
    import dots_pkg::*;

    localparam int unsigned SW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int unsigned CW = $clog2(NUM_TIMERS + 1);
    localparam int unsigned DW = 6;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DECODE = 10'b0000000010,
        S_HEAD   = 10'b0000000100,
        S_CHECK  = 10'b0000001000,
        S_DIV    = 10'b0000010000,
        S_INS    = 10'b0000100000,
        S_PLACE  = 10'b0001000000,
        S_EVENT  = 10'b0010000000,
        S_STAT   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state                 r_state;
    logic [MASK_W-1:0]      r_mask;
    logic [TICK_W-1:0]      r_now;
    logic [TICK_W-1:0]      r_start  [NUM_TIMERS];
    logic [TICK_W-1:0]      r_period [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  r_run;
    logic [SW-1:0]          r_rank   [NUM_TIMERS];
    t_in_item               r_req;
    logic [SW-1:0]          r_cur;
    logic [SW-1:0]          r_scan;
    logic [CW-1:0]          r_pos;
    logic [TICK_W-1:0]      r_rem;
    logic [TICK_W-1:0]      r_el;
    logic [TICK_W-1:0]      r_quo;
    logic [TICK_W:0]        r_part;
    logic [DW-1:0]          r_dcnt;
    logic [PER_W-1:0]       r_per;
    logic [TICK_W-1:0]      r_wait;
    logic                   r_out_valid;
    t_out_item              r_out;

    // shared unit: elapsed and remaining time of one slot
    logic [SW-1:0]          u_slot;
    logic [TICK_W-1:0]      u_iv, u_el, u_rem;
    logic                   u_due;

    function automatic logic [TICK_W-1:0] f_eff(input logic per, input logic [TICK_W-1:0] p);
        f_eff = (per && p == '0) ? TICK_W'(1) : p;
    endfunction

    function automatic logic f_per(input logic [MASK_W-1:0] m, input logic [SW-1:0] s);
        logic r;
        r = 1'b0;
        for (int k = 0; k < MASK_W; k++) begin
            if (k < NUM_TIMERS && SW'(k) == s) begin
                r = m[k];
            end
        end
        f_per = r;
    endfunction

    function automatic t_out_item f_event(input logic [SW-1:0] s,
                                          input logic [PER_W-1:0] per);
        t_out_item o;
        o                 = '0;
        o.result_kind     = KIND_EVENT;
        o.slot_id         = ID_W'(s);
        o.periods_elapsed = per;
        f_event = o;
    endfunction

    function automatic t_out_item f_status(input logic [ID_W-1:0] id,
                                           input logic [TICK_W-1:0] w,
                                           input logic ok,
                                           input logic [TICK_W-1:0] rem,
                                           input logic act,
                                           input logic [TICK_W-1:0] iv);
        t_out_item o;
        o             = '0;
        o.result_kind = KIND_STATUS;
        o.slot_id     = id;
        o.next_wait   = w;
        o.last_result = 1'b1;
        if (ok) begin
            o.remaining_ticks = rem;
            o.slot_active     = act;
            o.slot_interval   = iv;
        end
        f_status = o;
    endfunction

    always_comb begin
        u_iv  = f_eff(f_per(r_mask, u_slot), r_period[u_slot]);
        u_el  = r_now - r_start[u_slot];
        u_due = !(u_el < u_iv);
        u_rem = u_due ? '0 : (u_iv - u_el);
    end

    // slot holding a given rank, looked up for the scan rank
    logic [SW-1:0] w_at_slot;
    logic          w_at_hit;
    logic [CW-1:0] w_count;
    logic [SW-1:0] w_scan_rank;

    always_comb begin
        w_at_slot = '0;
        w_at_hit  = 1'b0;
        w_count   = '0;
        for (int t = 0; t < NUM_TIMERS; t++) begin
            if (r_run[t]) begin
                w_count = w_count + CW'(1);
            end
            if (r_run[t] && r_rank[t] == w_scan_rank) begin
                w_at_slot = SW'(t);
                w_at_hit  = 1'b1;
            end
        end
    end

    logic          w_id_ok;
    logic [SW-1:0] w_id;
    assign w_id    = SW'(r_req.timer_id);
    assign w_id_ok = 32'(r_req.timer_id) < NUM_TIMERS;

    // scan rank: count down from r_pos - 1 during insertion, else rank 0
    always_comb begin
        w_scan_rank = '0;
        if (r_state == S_INS) begin
            w_scan_rank = SW'(r_pos - CW'(1));
        end
    end

    always_comb begin
        u_slot = r_cur;
        if (r_state == S_CHECK || r_state == S_STAT) begin
            u_slot = w_at_slot;
        end else if (r_state == S_INS) begin
            u_slot = w_at_slot;
        end
        if (r_state == S_STAT && r_scan == SW'(1)) begin
            u_slot = w_id;
        end
    end

    logic [TICK_W:0] w_trial;
    assign w_trial = {r_part[TICK_W-1:0], r_el[TICK_W-1]} - {1'b0, u_iv};

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mask      <= '0;
            r_now       <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < NUM_TIMERS; t++) begin
                r_start[t]  <= '0;
                r_period[t] <= '0;
                r_rank[t]   <= '0;
            end
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        r_mask <= i_cfg_data;
                    end
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= S_DECODE;
                    end
                end
                S_DECODE: begin
                    if (r_req.operation == OP_TICK) begin
                        r_now   <= r_now + TICK_W'(r_req.tick_advance);
                        r_state <= S_CHECK;
                    end else if (w_id_ok && (r_req.operation == OP_START
                                 || r_req.operation == OP_RESTART
                                 || r_req.operation == OP_STOP)) begin
                        r_cur <= w_id;
                        if (r_run[w_id]) begin
                            r_run[w_id] <= 1'b0;
                            for (int t = 0; t < NUM_TIMERS; t++) begin
                                if (r_run[t] && r_rank[t] > r_rank[w_id]) begin
                                    r_rank[t] <= r_rank[t] - SW'(1);
                                end
                            end
                        end
                        if (r_req.operation == OP_STOP) begin
                            r_scan  <= '0;
                            r_state <= S_STAT;
                        end else begin
                            if (r_req.operation == OP_START) begin
                                r_period[w_id] <= r_req.interval_value;
                            end
                            r_start[w_id] <= r_now;
                            r_state       <= S_HEAD;
                        end
                    end else begin
                        r_scan  <= '0;
                        r_state <= S_STAT;
                    end
                end
                S_HEAD: begin
                    // latch own remaining time and list length, begin scan
                    r_rem   <= u_rem;
                    r_pos   <= w_count;
                    r_state <= (w_count == '0) ? S_PLACE : S_INS;
                end
                S_INS: begin
                    if (w_at_hit && !(r_rem < u_rem)) begin
                        r_state <= S_PLACE;
                    end else if (r_pos == CW'(1)) begin
                        r_pos   <= '0;
                        r_state <= S_PLACE;
                    end else begin
                        r_pos <= r_pos - CW'(1);
                    end
                end
                S_PLACE: begin
                    for (int t = 0; t < NUM_TIMERS; t++) begin
                        if (r_run[t] && CW'(r_rank[t]) >= r_pos) begin
                            r_rank[t] <= r_rank[t] + SW'(1);
                        end
                    end
                    r_rank[r_cur] <= SW'(r_pos);
                    r_run[r_cur]  <= 1'b1;
                    if (r_req.operation == OP_TICK) begin
                        r_state <= S_EVENT;
                    end else begin
                        r_scan  <= '0;
                        r_state <= S_STAT;
                    end
                end
                S_CHECK: begin
                    if (!r_out_valid) begin
                        if (w_at_hit && u_due) begin
                            r_cur <= w_at_slot;
                            r_el  <= u_el;
                            r_run[w_at_slot] <= 1'b0;
                            for (int t = 0; t < NUM_TIMERS; t++) begin
                                if (r_run[t] && r_rank[t] != '0) begin
                                    r_rank[t] <= r_rank[t] - SW'(1);
                                end
                            end
                            if (f_per(r_mask, w_at_slot)) begin
                                r_part  <= '0;
                                r_quo   <= '0;
                                r_dcnt  <= '0;
                                r_state <= S_DIV;
                            end else begin
                                r_per   <= '0;
                                r_state <= S_EVENT;
                            end
                        end else begin
                            r_scan  <= '0;
                            r_state <= S_STAT;
                        end
                    end
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (!w_trial[TICK_W]) begin
                        r_part <= {1'b0, w_trial[TICK_W-1:0]};
                    end else begin
                        r_part <= {r_part[TICK_W-1:0], r_el[TICK_W-1]};
                    end
                    r_el  <= {r_el[TICK_W-2:0], 1'b0};
                    r_quo <= {r_quo[TICK_W-2:0], !w_trial[TICK_W]};
                    r_dcnt <= r_dcnt + DW'(1);
                    if (r_dcnt == DW'(TICK_W - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // start advance by iv * n, using product from low 32 bits
                    r_start[r_cur] <= r_start[r_cur] + (u_iv * r_quo);
                    r_per   <= (r_quo > TICK_W'(16'hFFFF)) ? 16'hFFFF : r_quo[PER_W-1:0];
                    r_state <= S_HEAD;
                end
                S_EVENT: begin
                    if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out       <= f_event(r_cur, r_per);
                        r_state     <= S_CHECK;
                    end
                end
                S_STAT: begin
                    if (r_scan == '0) begin
                        r_wait <= w_at_hit ? u_rem : '1;
                        r_scan <= SW'(1);
                    end else if (!r_out_valid) begin
                        r_out_valid <= 1'b1;
                        r_out       <= f_status(r_req.timer_id, r_wait, w_id_ok, u_rem,
                                                r_run[w_id], r_period[w_id]);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: sv/dots_checker.sv
//------------------------------------------------------------------------------
// dots_checker
// port-level checks of the timer set, bound to the top level
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "deadline_ordered_timer_set_macros.svh"

module dots_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input dots_pkg::t_out_item o_out_data
);
    import dots_pkg::*;

    `DOTS_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "output changed under stall")
    `DOTS_ASSERT(a_last_kind, i_clk, i_rst_n, !o_out_valid || (o_out_data.last_result == o_out_data.result_kind), "last flag mismatch")
    `DOTS_ASSERT(a_accept_busy, i_clk, i_rst_n, i_in_valid && o_in_ready |=> !o_in_ready, "ready right after accept")
    `DOTS_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "output valid after reset")

endmodule

bind deadline_ordered_timer_set dots_checker u_dots_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
